### sv/assert_macros.svh
// Assertion helpers for the deframer blocks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge and is held off while in reset
`define RWD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### sv/rwd_pkg.sv
// ----------------------------------------------------------------------------
// rwd_pkg
// Shared types and constants for the RIFF/WAVE stream deframer.
// ----------------------------------------------------------------------------
package rwd_pkg;

    localparam logic [1:0] REG_MAX_FILE = 2'd0;
    localparam logic [1:0] REG_MIN_RATE = 2'd1;
    localparam logic [1:0] REG_MAX_RATE = 2'd2;

    localparam logic [28:0] MAX_FILE_RESET = 29'd268435456;
    localparam logic [31:0] MIN_RATE_RESET = 32'd8000;
    localparam logic [31:0] MAX_RATE_RESET = 32'd192000;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_NOT_WAVE = 4'd1;
    localparam logic [3:0] ST_SIZE     = 4'd2;
    localparam logic [3:0] ST_BAD_FMT  = 4'd3;
    localparam logic [3:0] ST_NO_DATA  = 4'd4;
    localparam logic [3:0] ST_CHANNELS = 4'd5;
    localparam logic [3:0] ST_RATE     = 4'd6;
    localparam logic [3:0] ST_FORMAT   = 4'd7;
    localparam logic [3:0] ST_DEPTH    = 4'd8;

    localparam logic [31:0] TAG_FMT    = 32'h20746D66;
    localparam logic [31:0] TAG_DATA   = 32'h61746164;
    localparam logic [15:0] FMT_EXT    = 16'hFFFE;
    localparam logic [15:0] FMT_PCM    = 16'd1;
    localparam logic [15:0] FMT_FLOAT  = 16'd3;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;

    typedef struct packed {
        logic        kind;
        logic [31:0] left;
        logic [31:0] right;
        logic        stereo;
        logic        flt;
        logic [31:0] rate;
        logic [3:0]  code;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic [7:0] riff_char(input logic [1:0] i);
        logic [7:0] c;
        unique case (i)
            2'd0: c = 8'h52;
            2'd1: c = 8'h49;
            2'd2: c = 8'h46;
            default: c = 8'h46;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] wave_char(input logic [1:0] i);
        logic [7:0] c;
        unique case (i)
            2'd0: c = 8'h57;
            2'd1: c = 8'h41;
            2'd2: c = 8'h56;
            default: c = 8'h45;
        endcase
        return c;
    endfunction

endpackage

### sv/riff_wave_stream_deframer.sv
// ----------------------------------------------------------------------------
// riff_wave_stream_deframer
// Byte-stream WAV parser emitting audio frames and one closing status.
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// in       sink       in_valid/in_stall  file_byte, end_of_file
// out      source     out_valid/out_stall result_kind .. last_of_run
// cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte per clock while in_stall is low; each byte is fully handled in the cycle it is taken.
// A byte may yield a frame and a status; the 4-entry result queue stalls input
// while fewer than two slots are free.
// Reset clears all parse state and loads the register defaults.
module riff_wave_stream_deframer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         file_byte,
    input  logic               end_of_file,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               result_kind,
    output logic signed [31:0] left_sample,
    output logic signed [31:0] right_sample,
    output logic               is_stereo,
    output logic               float_samples,
    output logic [31:0]        sample_rate,
    output logic [3:0]         status_code,
    output logic               last_of_run,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    rwd_pkg::push_t   push;
    rwd_pkg::result_t head;
    logic             room;
    logic             accept;

    assign in_stall = ~room;
    assign accept = in_valid & room;
    assign cfg_ready = 1'b1;

    rwd_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .file_byte   (file_byte),
        .end_of_file (end_of_file),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_idx     (cfg_index),
        .cfg_wdata   (cfg_data),
        .push        (push)
    );

    rwd_out_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign result_kind   = head.kind;
    assign left_sample   = head.left;
    assign right_sample  = head.right;
    assign is_stereo     = head.stereo;
    assign float_samples = head.flt;
    assign sample_rate   = head.rate;
    assign status_code   = head.code;
    assign last_of_run   = head.last;

endmodule

### sv/rwd_parser.sv
// ----------------------------------------------------------------------------
// rwd_parser
// Chunk walker, fmt capture and sample assembly; one byte per cycle while accept is high.
// ----------------------------------------------------------------------------
module rwd_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        file_byte,
    input  logic              end_of_file,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_idx,
    input  logic [31:0]       cfg_wdata,
    output rwd_pkg::push_t    push
);

    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_CHUNK  = 7'b0000010,
        PH_FMT    = 7'b0000100,
        PH_SKIP   = 7'b0001000,
        PH_DATA   = 7'b0010000,
        PH_DONE   = 7'b0100000,
        PH_DRAIN  = 7'b1000000
    } phase_t;

    logic [28:0] max_file_reg;
    logic [31:0] min_rate_reg, max_rate_reg;

    phase_t      phase_reg, phase_next;
    logic [28:0] seen_reg, seen_next;
    logic        match_reg, match_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [4:0]  bo_reg, bo_next;
    logic [32:0] skip_reg, skip_next;
    logic [15:0] fmt_reg, fmt_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] drem_reg, drem_next;
    logic [31:0] shift_reg, shift_next;
    logic [1:0]  sidx_reg, sidx_next;
    logic        cidx_reg, cidx_next;
    logic [31:0] held_reg, held_next;

    logic [29:0] count;
    logic        mismatch;
    logic [4:0]  bo_inc;
    logic [2:0]  bps;
    logic [1:0]  sh;
    logic        code_v, frame_v, do_clear;
    logic [3:0]  code;
    logic [31:0] fl, fr;
    logic [3:0]  chk;
    rwd_pkg::result_t st_res, fr_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_file_reg <= rwd_pkg::MAX_FILE_RESET;
            min_rate_reg <= rwd_pkg::MIN_RATE_RESET;
            max_rate_reg <= rwd_pkg::MAX_RATE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                rwd_pkg::REG_MAX_FILE: max_file_reg <= cfg_wdata[28:0];
                rwd_pkg::REG_MIN_RATE: min_rate_reg <= cfg_wdata;
                rwd_pkg::REG_MAX_RATE: max_rate_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stream check at the data header, in priority order
    always_comb
    begin
        if (chan_reg != 16'd1 && chan_reg != 16'd2)
            chk = rwd_pkg::ST_CHANNELS;
        else if (rate_reg < min_rate_reg || rate_reg > max_rate_reg)
            chk = rwd_pkg::ST_RATE;
        else if (fmt_reg != rwd_pkg::FMT_PCM && fmt_reg != rwd_pkg::FMT_FLOAT)
            chk = rwd_pkg::ST_FORMAT;
        else if (fmt_reg == rwd_pkg::FMT_PCM && bits_reg != 16'd16 && bits_reg != 16'd24
                 && bits_reg != 16'd32)
            chk = rwd_pkg::ST_DEPTH;
        else if (fmt_reg == rwd_pkg::FMT_FLOAT && bits_reg != 16'd32)
            chk = rwd_pkg::ST_DEPTH;
        else
            chk = rwd_pkg::ST_OK;
    end

    always_comb
    begin
        phase_next = phase_reg; seen_next = seen_reg; match_next = match_reg;
        tag_next = tag_reg; len_next = len_reg; bo_next = bo_reg; skip_next = skip_reg;
        fmt_next = fmt_reg; chan_next = chan_reg; rate_next = rate_reg;
        bits_next = bits_reg; drem_next = drem_reg; shift_next = shift_reg;
        sidx_next = sidx_reg; cidx_next = cidx_reg; held_next = held_reg;
        code_v = 1'b0; code = rwd_pkg::ST_OK; frame_v = 1'b0; fl = '0; fr = '0;
        do_clear = 1'b0;
        count = {1'b0, seen_reg} + 30'd1;
        mismatch = 1'b0;
        bo_inc = bo_reg + 5'd1;
        bps = bits_reg[5:3];
        sh = 2'(3'd4 - bps + {1'b0, sidx_reg});

        if (accept)
        begin
            if (phase_reg == PH_DRAIN)
            begin
                do_clear = end_of_file;
            end
            else
            begin
                if (seen_reg != '1)
                    seen_next = seen_reg + 29'd1;
                if (count > {1'b0, max_file_reg})
                begin
                    code_v = 1'b1;
                    code = rwd_pkg::ST_SIZE;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_HEADER:
                        begin
                            if (seen_reg < 29'd4 && file_byte != rwd_pkg::riff_char(seen_reg[1:0]))
                                mismatch = 1'b1;
                            if (seen_reg >= 29'd8 && seen_reg < 29'd12
                                && file_byte != rwd_pkg::wave_char(seen_reg[1:0]))
                                mismatch = 1'b1;
                            match_next = match_reg & ~mismatch;
                            if (count == 30'd12 && !end_of_file)
                            begin
                                if (!match_next)
                                begin
                                    code_v = 1'b1;
                                    code = rwd_pkg::ST_NOT_WAVE;
                                end
                                else
                                begin
                                    phase_next = PH_CHUNK;
                                    bo_next = '0;
                                end
                            end
                        end
                        PH_CHUNK:
                        begin
                            if (bo_reg < 5'd4)
                                tag_next = {file_byte, tag_reg[31:8]};
                            else
                                len_next = {file_byte, len_reg[31:8]};
                            bo_next = bo_inc;
                            if (bo_inc == 5'd8)
                            begin
                                bo_next = '0;
                                skip_next = {1'b0, len_next} + 33'(len_next[0]);
                                if (tag_next == rwd_pkg::TAG_FMT)
                                begin
                                    if (len_next < 32'd16)
                                    begin
                                        code_v = 1'b1;
                                        code = rwd_pkg::ST_BAD_FMT;
                                    end
                                    else
                                    begin
                                        phase_next = PH_FMT;
                                        shift_next = '0;
                                    end
                                end
                                else if (tag_next == rwd_pkg::TAG_DATA)
                                begin
                                    if (chk != rwd_pkg::ST_OK)
                                    begin
                                        code_v = 1'b1;
                                        code = chk;
                                    end
                                    else
                                    begin
                                        drem_next = len_next;
                                        shift_next = '0;
                                        sidx_next = '0;
                                        cidx_next = 1'b0;
                                        phase_next = (len_next != '0) ? PH_DATA : PH_DONE;
                                    end
                                end
                                else
                                begin
                                    phase_next = (skip_next != '0) ? PH_SKIP : PH_CHUNK;
                                end
                            end
                        end
                        PH_FMT, PH_SKIP:
                        begin
                            if (phase_reg == PH_FMT)
                            begin
                                priority if (bo_reg == 5'd0)
                                    fmt_next[7:0] = file_byte;
                                else if (bo_reg == 5'd1)
                                    fmt_next[15:8] = file_byte;
                                else if (bo_reg == 5'd2)
                                    chan_next[7:0] = file_byte;
                                else if (bo_reg == 5'd3)
                                    chan_next[15:8] = file_byte;
                                else if (bo_reg >= 5'd4 && bo_reg <= 5'd7)
                                begin
                                    unique case (bo_reg[1:0])
                                        2'd0: rate_next[7:0]   = file_byte;
                                        2'd1: rate_next[15:8]  = file_byte;
                                        2'd2: rate_next[23:16] = file_byte;
                                        default: rate_next[31:24] = file_byte;
                                    endcase
                                end
                                else if (bo_reg == 5'd14)
                                    bits_next[7:0] = file_byte;
                                else if (bo_reg == 5'd15)
                                    bits_next[15:8] = file_byte;
                                else if ((bo_reg == 5'd24 || bo_reg == 5'd25)
                                         && fmt_reg == rwd_pkg::FMT_EXT && len_reg >= 32'd40)
                                begin
                                    if (bo_reg == 5'd24)
                                        shift_next = {24'd0, file_byte};
                                    else
                                    begin
                                        fmt_next = {file_byte, shift_reg[7:0]};
                                        shift_next = '0;
                                    end
                                end
                                else ;
                            end
                            if (bo_reg != '1)
                                bo_next = bo_inc;
                            if (skip_reg != '0)
                                skip_next = skip_reg - 33'd1;
                            if (skip_next == '0)
                            begin
                                phase_next = PH_CHUNK;
                                bo_next = '0;
                            end
                        end
                        PH_DATA:
                        begin
                            shift_next = shift_reg | (32'(file_byte) << {sh, 3'b000});
                            if ({1'b0, sidx_reg} + 3'd1 >= bps)
                            begin
                                if (chan_reg == 16'd2 && !cidx_reg)
                                begin
                                    held_next = shift_next;
                                    cidx_next = 1'b1;
                                end
                                else
                                begin
                                    frame_v = 1'b1;
                                    fl = (chan_reg == 16'd2) ? held_reg : shift_next;
                                    fr = (chan_reg == 16'd2) ? shift_next : 32'd0;
                                    cidx_next = 1'b0;
                                end
                                shift_next = '0;
                                sidx_next = '0;
                            end
                            else
                            begin
                                sidx_next = sidx_reg + 2'd1;
                            end
                            drem_next = drem_reg - 32'd1;
                            if (drem_next == '0)
                                phase_next = PH_DONE;
                        end
                        default: ;
                    endcase
                end

                if (end_of_file && !code_v)
                begin
                    code_v = 1'b1;
                    unique case (phase_next)
                        PH_HEADER: code = rwd_pkg::ST_SIZE;
                        PH_FMT: code = (bo_next < 5'd16) ? rwd_pkg::ST_BAD_FMT
                                                         : rwd_pkg::ST_NO_DATA;
                        PH_DATA, PH_DONE: code = rwd_pkg::ST_OK;
                        default: code = rwd_pkg::ST_NO_DATA;
                    endcase
                end
                if (code_v)
                begin
                    if (end_of_file)
                        do_clear = 1'b1;
                    else
                        phase_next = PH_DRAIN;
                end
                else if (end_of_file)
                begin
                    do_clear = 1'b1;
                end
            end
        end

        // result fields see the updated fmt values, before any clear
        st_res.kind = 1'b1;
        st_res.left = '0;
        st_res.right = '0;
        st_res.stereo = (chan_next == 16'd2);
        st_res.flt = (fmt_next == rwd_pkg::FMT_FLOAT);
        st_res.rate = rate_next;
        st_res.code = code;
        st_res.last = 1'b1;
        fr_res = st_res;
        fr_res.kind = 1'b0;
        fr_res.left = fl;
        fr_res.right = fr;
        fr_res.code = rwd_pkg::ST_OK;
        fr_res.last = ~code_v;

        push.n = {1'b0, frame_v} + {1'b0, code_v};
        push.r0 = frame_v ? fr_res : st_res;
        push.r1 = st_res;

        if (do_clear)
        begin
            phase_next = PH_HEADER; seen_next = '0; match_next = 1'b1;
            tag_next = '0; len_next = '0; bo_next = '0; skip_next = '0;
            fmt_next = '0; chan_next = '0; rate_next = '0; bits_next = '0;
            drem_next = '0; shift_next = '0; sidx_next = '0; cidx_next = 1'b0;
            held_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER; seen_reg <= '0; match_reg <= 1'b1;
            tag_reg <= '0; len_reg <= '0; bo_reg <= '0; skip_reg <= '0;
            fmt_reg <= '0; chan_reg <= '0; rate_reg <= '0; bits_reg <= '0;
            drem_reg <= '0; shift_reg <= '0; sidx_reg <= '0; cidx_reg <= 1'b0;
            held_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next; seen_reg <= seen_next; match_reg <= match_next;
            tag_reg <= tag_next; len_reg <= len_next; bo_reg <= bo_next;
            skip_reg <= skip_next; fmt_reg <= fmt_next; chan_reg <= chan_next;
            rate_reg <= rate_next; bits_reg <= bits_next; drem_reg <= drem_next;
            shift_reg <= shift_next; sidx_reg <= sidx_next; cidx_reg <= cidx_next;
            held_reg <= held_next;
        end
    end

endmodule

### sv/rwd_out_fifo.sv
// ----------------------------------------------------------------------------
// rwd_out_fifo
// Result queue; takes up to two results per cycle, delivers one while out_stall is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rwd_out_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  rwd_pkg::push_t    push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_stall,
    output rwd_pkg::result_t  head
);

    rwd_pkg::result_t mem [rwd_pkg::FIFO_DEPTH];

    logic [rwd_pkg::FIFO_AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [rwd_pkg::FIFO_AW:0]   cnt_reg, cnt_next;
    logic                        pop;

    assign out_valid = (cnt_reg != '0);
    assign pop = out_valid & ~out_stall;
    // two free slots needed: one item may cause a frame and a status
    assign room = (cnt_reg <= 3'(rwd_pkg::FIFO_DEPTH - 2));
    assign head = mem[rp_reg];

    always_comb
    begin
        wp_next = wp_reg + push.n;
        rp_next = rp_reg + {{(rwd_pkg::FIFO_AW-1){1'b0}}, pop};
        cnt_next = cnt_reg + {1'b0, push.n} - {{rwd_pkg::FIFO_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem[wp_reg] <= push.r0;
        if (push.n == 2'd2)
            mem[wp_reg + 2'd1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    `RWD_ASSERT(a_no_overflow, ({1'b0, cnt_reg} + 4'(push.n) <= 4'(rwd_pkg::FIFO_DEPTH)), "result queue overflow")
    `RWD_ASSERT(a_pop_only, (pop && push.n == 2'd0 |=> cnt_reg == $past(cnt_reg) - 3'd1), "count off after pop")
    `RWD_ASSERT(a_pair_last, (push.n == 2'd2 |-> !push.r0.last && push.r1.last), "bad last flags in pair")

endmodule
